>>> hw/rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types, constants and helpers for the 2x2 box downsampler
// Widths of the pixel channels, counters and line store, and the pair-sum
// packing used by both the line store and the averaging stage.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // Largest source width the line store is sized for.
    localparam int MAX_WIDTH   = 8192;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);

    localparam int WIDTH_REG_W  = 14;
    localparam int HEIGHT_REG_W = 16;
    localparam int ROW_W        = HEIGHT_REG_W;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 8;
    localparam int PIX_W  = NUM_CH * CH_W;
    localparam int SUM_W  = CH_W + 1;
    localparam int PAIR_W = NUM_CH * SUM_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes, selected by address bit 2.
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [PAIR_W-1:0] pair_t;

    // Frame geometry derived from the configuration registers.
    typedef struct packed {
        logic             w_one;     // effective width is one
        logic             h_one;     // effective height is one
        logic [COL_W-1:0] w_last;    // last source column
        logic [ROW_W-1:0] h_last;    // last source row
        logic [COL_W-1:0] col_last;  // last column that is averaged
        logic [ROW_W-1:0] row_last;  // last row that is averaged
    } rbd_geom_t;

    // Side information that travels with an averaged pair.
    typedef struct packed {
        logic use_line;   // partner row comes from the line store
        logic row_end;
        logic frame_end;
    } rbd_tag_t;

    // Four channel-wise sums of two pixels, 9 bits apart.
    function automatic pair_t pair_of(input pixel_t a, input pixel_t b);
        pair_t s;
        s = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            s[c*SUM_W +: SUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/rbd_cfg.sv
// ----------------------------------------------------------------------------
// rbd_cfg: configuration registers
// APB register file for the source size, with the derived frame geometry
// and a pulse on every register write that restarts the frame.
// ----------------------------------------------------------------------------
module rbd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbd_pkg::APB_AW-1:0] paddr,
    input  logic [rbd_pkg::APB_DW-1:0] pwdata,
    output logic [rbd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rbd_pkg::rbd_geom_t         geom,
    output logic                       restart
);
    import rbd_pkg::*;

    logic [WIDTH_REG_W-1:0]  src_width_reg;
    logic [HEIGHT_REG_W-1:0] src_height_reg;
    logic [WEFF_W-1:0]       w_eff;
    logic [ROW_W-1:0]        h_eff;
    logic [WEFF_W-1:0]       w_even;
    logic [ROW_W-1:0]        h_even;
    logic [WEFF_W-1:0]       w_last_full;
    logic [WEFF_W-1:0]       col_last_full;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= WIDTH_REG_W'(1);
            src_height_reg <= HEIGHT_REG_W'(1);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SRC_WIDTH:  prdata = APB_DW'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(src_height_reg);
            default:        prdata = '0;
        endcase
    end

    // A size of zero counts as one; widths beyond the line store are clamped.
    always_comb begin
        priority if (src_width_reg == '0) begin
            w_eff = WEFF_W'(1);
        end else if (WEFF_W'(src_width_reg) > WEFF_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(src_width_reg);
        end
        h_eff         = (src_height_reg == '0) ? ROW_W'(1) : src_height_reg;
        w_even        = {w_eff[WEFF_W-1:1], 1'b0};
        h_even        = {h_eff[ROW_W-1:1], 1'b0};
        w_last_full   = w_eff - WEFF_W'(1);
        col_last_full = w_even - WEFF_W'(1);
        geom.w_one    = (w_eff == WEFF_W'(1));
        geom.h_one    = (h_eff == ROW_W'(1));
        geom.w_last   = w_last_full[COL_W-1:0];
        geom.h_last   = h_eff - ROW_W'(1);
        geom.col_last = col_last_full[COL_W-1:0];
        geom.row_last = h_even - ROW_W'(1);
    end

endmodule

>>> hw/rtl/rbd_line_ram.sv
// ----------------------------------------------------------------------------
// rbd_line_ram: single-port line store
// Synchronous RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbd_line_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 36
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> hw/rtl/rbd_avg.sv
// ----------------------------------------------------------------------------
// rbd_avg: vertical combine and output register
// Holds a pair sum while the line store read completes, adds the partner
// row with rounding and presents the result on the output stream.
// ----------------------------------------------------------------------------
module rbd_avg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  rbd_pkg::pair_t         pair_in,
    input  rbd_pkg::rbd_tag_t      tag_in,
    input  rbd_pkg::pair_t         line_rdata,
    output logic                   take_ok,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [rbd_pkg::PIX_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);
    import rbd_pkg::*;

    logic     s1_valid_reg;
    pair_t    s1_pair_reg;
    rbd_tag_t s1_tag_reg;
    logic     out_free;
    logic     s1_move;
    pair_t    other;
    pixel_t   avg;
    logic [SUM_W:0] total;

    assign out_free = !m_tvalid || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign take_ok  = !s1_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (load) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_pair_reg <= pair_in;
            s1_tag_reg  <= tag_in;
        end
        if (s1_move) begin
            m_tdata <= avg;
            m_tlast <= s1_tag_reg.row_end;
            m_tuser <= s1_tag_reg.frame_end;
        end
    end

    // Two 9-bit pair sums plus the rounding term stay below 1024, so the
    // mean always fits in eight bits.
    always_comb begin
        other = s1_tag_reg.use_line ? line_rdata : s1_pair_reg;
        avg   = '0;
        total = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            total = (SUM_W+1)'(s1_pair_reg[c*SUM_W +: SUM_W])
                  + (SUM_W+1)'(other[c*SUM_W +: SUM_W]) + (SUM_W+1)'(2);
            avg[c*CH_W +: CH_W] = total[SUM_W:2];
        end
    end

endmodule

>>> hw/rtl/rgba_box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2: 2x2 box-filter downsampler for RGBA pixels
// Halves a raster-order stream of premultiplied 8-bit RGBA pixels in both
// directions, rounding each channel of every 2x2 block to its mean.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock and produces one output pixel
// for every complete 2x2 block. The line store is read at the edge that
// accepts the pixel completing a block, and the averaged pixel is
// registered into the output register, raising m_tvalid, once that
// register is free. s_tready drops only while an averaged pixel waits in the
// holding stage behind an output transaction that m_tready is stalling;
// with m_tready high, pixels are accepted back to back. Program src_width
// (address 0) and src_height (address 4) while the stream is idle; any
// write restarts the frame at its first pixel. The output image is
// max(1, W/2) by max(1, H/2); with an odd size above one the last column or
// row is consumed but ignored, and a size of one uses that single column or
// row twice. Widths above 8192 are clamped to 8192 and a size of zero
// counts as one. m_tlast marks the last pixel of each output row and
// m_tuser the last pixel of the image.
module rgba_box_downsample_2x2 (
    input  logic        aclk,
    input  logic        aresetn,
    // Source pixels: blue[7:0], green[15:8], red[23:16], alpha[31:24].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Averaged pixels: blue[7:0], green[15:8], red[23:16], alpha[31:24].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,   // last pixel of an output row
    output logic        m_tuser,   // frame_end: last pixel of the image
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbd_pkg::*;

    rbd_geom_t        geom;
    logic             restart;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pixel_t           pending_reg;
    logic             take_ok;
    logic             accept;
    pair_t            pair;
    pair_t            line_rdata;
    rbd_tag_t         tag;
    logic             col_keep;   // column belongs to an averaged block
    logic             row_keep;   // row belongs to an averaged block
    logic             col_odd;
    logic             row_odd;
    logic             save_pending;
    logic             have_pair;
    logic             line_we;
    logic             line_re;
    logic             emit;

    rbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .restart (restart)
    );

    assign s_tready = take_ok;
    assign accept   = s_tvalid && s_tready;

    // Source position bookkeeping.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg == geom.w_last) begin
                col_next = '0;
                row_next = (row_reg == geom.h_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Horizontal pairing: an even column waits in the pending register for
    // its odd partner; a one-pixel-wide image pairs each pixel with itself.
    always_comb begin
        col_odd      = col_reg[0];
        row_odd      = row_reg[0];
        col_keep     = geom.w_one || (col_reg <= geom.col_last);
        row_keep     = geom.h_one || (row_reg <= geom.row_last);
        save_pending = accept && !geom.w_one && col_keep && !col_odd && row_keep;
        have_pair    = accept && col_keep && (geom.w_one || col_odd);
        pair         = geom.w_one ? pair_of(s_tdata, s_tdata) : pair_of(pending_reg, s_tdata);
        line_we      = have_pair && !geom.h_one && row_keep && !row_odd;
        line_re      = have_pair && !geom.h_one && row_keep && row_odd;
        emit         = have_pair && (geom.h_one || line_re);
        tag.use_line  = !geom.h_one;
        tag.row_end   = geom.w_one || (col_reg == geom.col_last);
        tag.frame_end = tag.row_end && (geom.h_one || (row_reg == geom.row_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (save_pending) begin
            pending_reg <= s_tdata;
        end
    end

    // Even rows store their pair sums; odd rows read them back. An entry is
    // always written at least one row before it is read, so the write and
    // the read of one entry never meet in the same cycle.
    rbd_line_ram #(
        .ADDR_W (LINE_AW),
        .DATA_W (PAIR_W)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .re    (line_re),
        .addr  (col_reg[COL_W-1:1]),
        .wdata (pair),
        .rdata (line_rdata)
    );

    rbd_avg u_avg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (emit),
        .pair_in    (pair),
        .tag_in     (tag),
        .line_rdata (line_rdata),
        .take_ok    (take_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTH
    a_frame_end_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= geom.w_last)
        else $error("column counter beyond source width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= geom.h_last)
        else $error("row counter beyond source height");

    a_line_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(line_we && line_re))
        else $error("line store read and written in one cycle");

    a_pending_only_even: assert property (@(posedge aclk) disable iff (!aresetn)
        save_pending |-> !have_pair)
        else $error("pixel both held and paired");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 2x2 RGBA box downsampler
// Streams source pixels through the block under a range of image sizes, with
// random source gaps and sink stalls, and checks every averaged pixel and its
// row and frame markers against a cycle-free software predictor.
// ----------------------------------------------------------------------------
// The bench is built from three cooperating processes. The initial block
// programs an image size over the register port, fills a queue of pending
// source pixels and then waits for the stream to drain before it moves on to
// the next size. The driver moves pixels from that queue onto the s_ channel
// in bursts, and every transaction that it sees accepted is handed to the
// predictor, which updates its own copy of the counters, the held even-column
// pixel and the line of pair sums, and queues the averaged pixel when the
// source pixel completes a 2x2 block. The monitor stalls the m_ channel on a
// pattern of its own and compares each result transaction with the oldest
// queued average, field by field.
module tb;
    import rbd_pkg::*;

    // The slowest correct run stays far below this many clock cycles.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles to let pass once nothing is expected, so that a source pixel
    // which produces no result has surely left the pipeline.
    localparam int LATENCY_SLACK = 6;
    // Source pixels sent with randomly chosen image sizes.
    localparam int RANDOM_PIXELS = 500;

    // One averaged output pixel as the block should present it.
    typedef struct {
        logic [NUM_CH-1:0][CH_W-1:0] chan;  // blue, green, red, alpha
        logic                        row_end;
        logic                        frame_end;
    } box_mean_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // blue[7:0], green[15:8], red[23:16], alpha[31:24]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // blue[7:0], green[15:8], red[23:16], alpha[31:24]
    logic        m_tlast;         // row_end
    logic        m_tuser;         // frame_end
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    rgba_box_downsample_2x2 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Predictor state. It mirrors the block from reset onward.
    logic [WIDTH_REG_W-1:0]      width_reg  = 1;
    logic [HEIGHT_REG_W-1:0]     height_reg = 1;
    int unsigned                 col_pos    = 0;
    int unsigned                 row_pos    = 0;
    pixel_t                      held_px    = '0;
    logic [NUM_CH-1:0][SUM_W-1:0] pair_line [LINE_DEPTH];

    pixel_t    pixel_q [$];  // source pixels not yet offered to the block
    box_mean_t mean_q  [$];  // averaged pixels the block still owes us

    string chan_names [NUM_CH] = '{"blue", "green", "red", "alpha"};

    int unsigned cycle_count     = 0;
    int unsigned mismatches      = 0;
    int unsigned pixels_accepted = 0;
    int unsigned means_checked   = 0;
    int unsigned row_end_seen    = 0;
    int unsigned frame_end_seen  = 0;
    int unsigned settings_used   = 0;

    // Advance the predictor by one accepted source pixel. Horizontal pairs are
    // formed on odd columns; an even row parks its pair sums in the line and
    // the following odd row combines with them into the output pixel. A width
    // or height of one pairs the single column or row with itself.
    function automatic void take_pixel(input pixel_t px);
        int unsigned                  w, h, dw, dh, c, r, idx, tot;
        logic [NUM_CH-1:0][SUM_W-1:0] hsum, vsum;
        logic                         last_row;
        box_mean_t                    mean;

        w = (width_reg == 0) ? 1 : width_reg;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h  = (height_reg == 0) ? 1 : height_reg;
        dw = (w / 2 == 0) ? 1 : w / 2;
        dh = (h / 2 == 0) ? 1 : h / 2;
        c  = col_pos;
        r  = row_pos;

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end

        if (w == 1) begin
            for (int ch = 0; ch < NUM_CH; ch++)
                hsum[ch] = px[ch*CH_W +: CH_W] + px[ch*CH_W +: CH_W];
        end else begin
            // The last column of an odd width is swallowed.
            if (c >= 2 * dw)
                return;
            if (c % 2 == 0) begin
                if (r < 2 * dh || h == 1)
                    held_px = px;
                return;
            end
            for (int ch = 0; ch < NUM_CH; ch++)
                hsum[ch] = held_px[ch*CH_W +: CH_W] + px[ch*CH_W +: CH_W];
        end
        idx = (c / 2) % LINE_DEPTH;

        if (h == 1) begin
            vsum     = hsum;
            last_row = 1'b1;
        end else begin
            // The last row of an odd height is swallowed as well.
            if (r >= 2 * dh)
                return;
            if (r % 2 == 0) begin
                pair_line[idx] = hsum;
                return;
            end
            vsum     = pair_line[idx];
            last_row = (r == 2 * dh - 1);
        end

        for (int ch = 0; ch < NUM_CH; ch++) begin
            tot          = int'(hsum[ch]) + int'(vsum[ch]) + 2;
            mean.chan[ch] = CH_W'(tot / 4);
        end
        mean.row_end   = (w == 1) || (c == 2 * dw - 1);
        mean.frame_end = mean.row_end && last_row;
        mean_q.push_back(mean);
    endfunction

    // Source driver. Pixels leave the queue in bursts of random length; a
    // burst sometimes holds 100 to 300 pixels with no gap between them. A pixel
    // on the bus is held until its transaction completes.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 8;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_pixel(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 5);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. The sink cycles through four stall styles: always
    // ready, mostly ready, ready a quarter of the time, and mostly stalled.
    int unsigned ready_tick = 0;

    always @(posedge aclk) begin : monitor
        box_mean_t want;
        logic      ready_next;

        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected output pixel: got %h", m_tdata);
                    mismatches++;
                end else begin
                    want = mean_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (m_tdata[ch*CH_W +: CH_W] !== want.chan[ch]) begin
                            $error("%s: expected %0d, got %0d", chan_names[ch],
                                   want.chan[ch], m_tdata[ch*CH_W +: CH_W]);
                            mismatches++;
                        end
                    end
                    if (m_tlast !== want.row_end) begin
                        $error("row_end: expected %0d, got %0d", want.row_end, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end, m_tuser);
                        mismatches++;
                    end
                    means_checked++;
                    row_end_seen   += want.row_end;
                    frame_end_seen += want.frame_end;
                end
            end

            ready_tick++;
            case ((ready_tick / 300) % 4)
                0:       ready_next = 1'b1;
                1:       ready_next = ($urandom_range(0, 9) < 7);
                2:       ready_next = (ready_tick % 4 == 0);
                default: ready_next = ($urandom_range(0, 9) < 3);
            endcase
            m_tready <= ready_next;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Writes one register, then reads it back. The predictor takes the new
    // value at the very edge where the block does, and restarts its frame.
    task automatic reg_access(input logic sel, input logic [31:0] value);
        logic [31:0] stored;

        stored = (sel == REG_SRC_WIDTH) ? 32'(value[WIDTH_REG_W-1:0])
                                        : 32'(value[HEIGHT_REG_W-1:0]);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_SRC_WIDTH)
            width_reg = value[WIDTH_REG_W-1:0];
        else
            height_reg = value[HEIGHT_REG_W-1:0];
        col_pos = 0;
        row_pos = 0;

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored) begin
            $error("prdata: expected %0d, got %0d", stored, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_size(input logic [31:0] wval, input logic [31:0] hval);
        reg_access(REG_SRC_WIDTH, wval);
        reg_access(REG_SRC_HEIGHT, hval);
        settings_used++;
    endtask

    // Random pixels, with a share of all-black and all-white ones so that the
    // rounding sees both ends of each channel.
    task automatic queue_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       pixel_q.push_back('0);
                1:       pixel_q.push_back('1);
                default: pixel_q.push_back($urandom());
            endcase
        end
    endtask

    // Returns once the stream is empty and every queued average has arrived,
    // plus the latency slack for pixels that produce no result.
    task automatic wait_idle();
        @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || mean_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY_SLACK) @(negedge aclk);
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned wv, hv, we, he, frame_px, n;
        logic [31:0] wreg, hreg;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Out of reset the size is 1x1, so every pixel is its own average.
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'hFFFF_FFFF);
        pixel_q.push_back(32'h807F_01FE);
        wait_idle();

        // A 2x2 image: saturated white, then small values that exercise
        // the rounding in each channel, with a sum that rounds half up in red.
        set_size(2, 2);
        repeat (4) pixel_q.push_back(32'hFFFF_FFFF);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0103_0201);
        pixel_q.push_back(32'h0001_0000);
        pixel_q.push_back(32'h0202_0300);
        wait_idle();

        // Odd sizes drop the last column and the last row.
        set_size(3, 3);
        queue_random(9);
        wait_idle();

        // A size of zero behaves as a size of one.
        set_size(0, 0);
        queue_random(2);
        wait_idle();

        // A wider image whose whole row of line entries is written and read
        // back. The source holds off between the two rows until all is idle.
        set_size(64, 2);
        queue_random(64);
        wait_idle();
        queue_random(64);
        wait_idle();

        // Largest register values: width clamps to the line size and the
        // height is never reached, so the next write cuts the frame short.
        set_size(2**WIDTH_REG_W - 1, 2**HEIGHT_REG_W - 1);
        queue_random(40);
        wait_idle();
        set_size(2, 2**HEIGHT_REG_W - 1);
        queue_random(30);
        wait_idle();

        // Random sizes, mostly complete frames with random content. Some
        // frames are cut short, some writes carry junk above the register
        // width, and some frames pause midway until the results drain.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       wv = 0;
                1:       wv = 1;
                2:       wv = $urandom_range(13, 48);
                default: wv = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       hv = 0;
                1:       hv = 1;
                default: hv = $urandom_range(2, 9);
            endcase
            we       = (wv == 0) ? 1 : wv;
            he       = (hv == 0) ? 1 : hv;
            frame_px = we * he;
            n        = (frame_px > 120) ? frame_px : frame_px * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);

            wreg = wv;
            hreg = hv;
            if ($urandom_range(0, 3) == 0) begin
                wreg = wreg | ($urandom() << WIDTH_REG_W);
                hreg = hreg | ($urandom() << HEIGHT_REG_W);
            end
            set_size(wreg, hreg);

            if (n > 4 && $urandom_range(0, 2) == 0) begin
                queue_random(n / 2);
                wait_idle();
                queue_random(n - n / 2);
            end else begin
                queue_random(n);
            end
            wait_idle();
            random_sent += n;
        end

        if (mean_q.size() != 0) begin
            $error("%0d averaged pixels never arrived", mean_q.size());
            mismatches++;
        end
        $display("Sent %0d source pixels under %0d image sizes, clamped width included.",
                 pixels_accepted, settings_used);
        $display("Checked %0d averaged pixels with %0d row ends and %0d frame ends.",
                 means_checked, row_end_seen, frame_end_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_cfg.sv
hw/rtl/rbd_line_ram.sv
hw/rtl/rbd_avg.sv
hw/rtl/rgba_box_downsample_2x2.sv
tb/tb.sv
